// ===== src/gar_pkg.sv =====
// gar_pkg: shared types and constants of the glyph address resolver
// no dependencies; imported by glyph_address_resolver

package gar_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_TABLE_MODE      = 3'd0;
   localparam csr_index_type REG_GLYPH_BYTES     = 3'd1;
   localparam csr_index_type REG_RANGE_ENTRIES   = 3'd2;
   localparam csr_index_type REG_TABLE_ENTRIES   = 3'd3;
   localparam csr_index_type REG_CACHE_VALID     = 3'd4;
   localparam csr_index_type REG_BACKING_PRESENT = 3'd5;

   typedef logic [1:0] source_type;

   localparam source_type SRC_NONE    = 2'd0;
   localparam source_type SRC_HIT     = 2'd1;
   localparam source_type SRC_BACKING = 2'd2;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   localparam logic [27:0] HEADER_BYTES   = 28'd16;
   localparam logic [31:0] BACKING_GLYPHS = 32'h0001_0000;
   localparam logic [31:0] KEY_MAX        = 32'h0000_FFFF;
   localparam logic [31:0] RANGE_FIRST    = 32'h0000_0000;
   localparam logic [16:0] RANGE_RESET    = 17'd3000;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_CMP  = 5'b00100,
      S_MUL  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

endpackage

// ===== src/gar_ram.sv =====
// gar_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the sorted codepoint table

module gar_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/glyph_address_resolver.sv =====
// glyph_address_resolver: code point to glyph byte offset, range or table cache
// depends on gar_pkg and gar_ram
// a load, a failed check or a miss without fallback goes straight to publish; a hit or
// fallback first passes the multiply state; a table search runs k probes of one ram read
// plus one compare, k <= floor(log2(min(table_entries, TABLE_DEPTH)))+1; publish waits on rsp_stall
// one transaction at a time, req_stall holds new requests until publish; reset: synchronous
module glyph_address_resolver
   import gar_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [31:0]            req_codepoint,
   input  logic [15:0]            req_requested_size,
   input  logic [11:0]            req_table_slot,
   input  logic [15:0]            req_table_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_source,
   output logic [27:0]            rsp_byte_offset,
   output logic [12:0]            rsp_bytes_returned,
   output logic [31:0]            rsp_hits_total,
   output logic [31:0]            rsp_misses_total,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   // configuration
   logic        table_mode_ff;
   logic [12:0] glyph_bytes_ff;
   logic [16:0] range_entries_ff;
   logic [12:0] table_entries_ff;
   logic        cache_valid_ff;
   logic        backing_present_ff;

   // sequencer
   state_type   state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [31:0] cp_ff, cp_in;
   logic [16:0] op_ff, op_in;
   logic [27:0] base_ff, base_in;
   logic [29:0] prod_ff, prod_in;
   source_type  src_ff, src_in;
   logic        hit_ff, hit_in, miss_ff, miss_in;

   logic [31:0] hit_counter_ff, hit_counter_in;
   logic [31:0] miss_counter_ff, miss_counter_in;

   logic        rsp_valid_ff, rsp_valid_in;
   source_type  rsp_source_ff;
   logic [27:0] rsp_byte_offset_ff;
   logic [12:0] rsp_bytes_returned_ff;
   logic [31:0] rsp_hits_total_ff, rsp_misses_total_ff;

   logic        req_accept, rsp_load;
   logic        precheck_ok, req_key_ok, range_hit, fb_req_ok, slot_ok;
   logic [31:0] rel;
   logic [CW-1:0] n_entries;
   logic [27:0] table_base;
   logic [27:0] offset_sum;
   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0] ram_rdata;
   logic [16:0] slot_ext;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   assign precheck_ok = cache_valid_ff && (glyph_bytes_ff != 13'd0)
                        && ({3'b000, glyph_bytes_ff} == req_requested_size);
   assign n_entries   = ({19'd0, table_entries_ff} > 32'(TABLE_DEPTH)) ?
                        CW'(TABLE_DEPTH) : CW'(table_entries_ff);
   assign table_base  = HEADER_BYTES + (28'(n_entries) << 1);
   assign req_key_ok  = (req_codepoint <= KEY_MAX);
   assign rel         = req_codepoint - RANGE_FIRST;
   assign range_hit   = (rel < {15'd0, range_entries_ff});
   assign fb_req_ok   = backing_present_ff && (req_codepoint < BACKING_GLYPHS);
   assign slot_ext    = {5'd0, req_table_slot};
   assign slot_ok     = ({20'd0, req_table_slot} < 32'(TABLE_DEPTH));
   assign ram_waddr   = slot_ext[AW-1:0];
   assign ram_raddr   = mid_in[AW-1:0];
   assign offset_sum  = base_ff + prod_ff[27:0];

   gar_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_table_word),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      logic [CW-1:0] lo_nx;
      logic [CW-1:0] hi_nx;
      lo_nx    = lo_ff;
      hi_nx    = hi_ff;
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      cp_in    = cp_ff;
      op_in    = op_ff;
      base_in  = base_ff;
      prod_in  = prod_ff;
      src_in   = src_ff;
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      ram_we   = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cp_in    = req_codepoint;
               hit_in   = 1'b0;
               miss_in  = 1'b0;
               src_in   = SRC_NONE;
               state_in = S_DONE;
               if (req_func == FUNC_LOAD) begin
                  ram_we = slot_ok;
               end else if (precheck_ok) begin
                  if (table_mode_ff && (n_entries != '0) && req_key_ok) begin
                     lo_in    = '0;
                     hi_in    = n_entries;
                     state_in = S_READ;
                  end else if (!table_mode_ff && range_hit) begin
                     hit_in   = 1'b1;
                     src_in   = SRC_HIT;
                     op_in    = rel[16:0];
                     base_in  = HEADER_BYTES;
                     state_in = S_MUL;
                  end else begin
                     miss_in = 1'b1;
                     if (fb_req_ok) begin
                        src_in   = SRC_BACKING;
                        op_in    = {1'b0, req_codepoint[15:0]};
                        base_in  = '0;
                        state_in = S_MUL;
                     end
                  end
               end
            end
         end
         S_READ: begin
            mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ram_rdata == cp_ff[15:0]) begin
               hit_in   = 1'b1;
               src_in   = SRC_HIT;
               op_in    = 17'(mid_ff);
               base_in  = table_base;
               state_in = S_MUL;
            end else begin
               if (ram_rdata < cp_ff[15:0]) begin
                  lo_nx = mid_ff + CW'(1);
               end else begin
                  hi_nx = mid_ff;
               end
               lo_in = lo_nx;
               hi_in = hi_nx;
               if (lo_nx < hi_nx) begin
                  state_in = S_READ;
               end else begin
                  miss_in = 1'b1;
                  if (backing_present_ff) begin
                     src_in   = SRC_BACKING;
                     op_in    = {1'b0, cp_ff[15:0]};
                     base_in  = '0;
                     state_in = S_MUL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_MUL: begin
            prod_in  = 30'(op_ff) * 30'(glyph_bytes_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign hit_counter_in  = hit_counter_ff + {31'd0, hit_ff};
   assign miss_counter_in = miss_counter_ff + {31'd0, miss_ff};
   assign rsp_valid_in    = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_mode_ff      <= 1'b0;
         glyph_bytes_ff     <= '0;
         range_entries_ff   <= RANGE_RESET;
         table_entries_ff   <= '0;
         cache_valid_ff     <= 1'b0;
         backing_present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TABLE_MODE:      table_mode_ff      <= csr_wdata[0];
            REG_GLYPH_BYTES:     glyph_bytes_ff     <= csr_wdata[12:0];
            REG_RANGE_ENTRIES:   range_entries_ff   <= csr_wdata[16:0];
            REG_TABLE_ENTRIES:   table_entries_ff   <= csr_wdata[12:0];
            REG_CACHE_VALID:     cache_valid_ff     <= csr_wdata[0];
            REG_BACKING_PRESENT: backing_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         hit_counter_ff  <= '0;
         miss_counter_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            hit_counter_ff  <= hit_counter_in;
            miss_counter_ff <= miss_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      cp_ff   <= cp_in;
      op_ff   <= op_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      src_ff  <= src_in;
      hit_ff  <= hit_in;
      miss_ff <= miss_in;
      if (rsp_load) begin
         rsp_source_ff         <= src_ff;
         rsp_byte_offset_ff    <= (src_ff == SRC_NONE) ? 28'd0 : offset_sum;
         rsp_bytes_returned_ff <= (src_ff == SRC_NONE) ? 13'd0 : glyph_bytes_ff;
         rsp_hits_total_ff     <= hit_counter_in;
         rsp_misses_total_ff   <= miss_counter_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_source         = rsp_source_ff;
   assign rsp_byte_offset    = rsp_byte_offset_ff;
   assign rsp_bytes_returned = rsp_bytes_returned_ff;
   assign rsp_hits_total     = rsp_hits_total_ff;
   assign rsp_misses_total   = rsp_misses_total_ff;

`ifndef ASSERT_OFF
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (lo_ff < hi_ff))
      else $error("search window empty while probing");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> ($stable(hit_counter_ff) && $stable(miss_counter_ff)))
      else $error("counter moved outside response publish");

   a_hit_miss_excl: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !(hit_ff && miss_ff))
      else $error("transaction counted as both hit and miss");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_source == SRC_NONE)) |->
      ((rsp_byte_offset == 28'd0) && (rsp_bytes_returned == 13'd0)))
      else $error("empty response carries an offset or size");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for glyph_address_resolver, range and table cache modes
// depends on gar_pkg and the glyph_address_resolver rtl; a class predicts every response
// stimulus is directed corner transactions, a partial table load, then randomized phases

`timescale 1ns / 100ps

module tb;
   import gar_pkg::*;

   localparam int unsigned TABLE_DEPTH  = 4096;
   localparam int unsigned LOADED_SLOTS = 256;
   localparam int unsigned SPARSE_STEP  = 64;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned TAIL_CYCLES  = 40;

   typedef struct packed {
      logic        func;
      logic [31:0] codepoint;
      logic [15:0] requested_size;
      logic [11:0] table_slot;
      logic [15:0] table_word;
   } resolver_req_type;

   typedef struct packed {
      source_type  source;
      logic [27:0] byte_offset;
      logic [12:0] bytes_returned;
      logic [31:0] hits_total;
      logic [31:0] misses_total;
   } resolver_rsp_type;

   class resolver_scoreboard;
      bit [15:0]        cp_table [TABLE_DEPTH];
      logic [31:0]      hit_count;
      logic [31:0]      miss_count;
      logic             table_mode;
      logic [12:0]      glyph_bytes;
      logic [16:0]      range_entries;
      logic [12:0]      table_entries;
      logic             cache_valid;
      logic             backing_present;
      resolver_rsp_type offsets_due [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      fallbacks;
      int unsigned      loads;

      function new();
         hit_count       = '0;
         miss_count      = '0;
         table_mode      = 1'b0;
         glyph_bytes     = '0;
         range_entries   = RANGE_RESET;
         table_entries   = '0;
         cache_valid     = 1'b0;
         backing_present = 1'b0;
         errors          = 0;
         checked         = 0;
         fallbacks       = 0;
         loads           = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_TABLE_MODE:      table_mode      = value[0];
            REG_GLYPH_BYTES:     glyph_bytes     = value[12:0];
            REG_RANGE_ENTRIES:   range_entries   = value[16:0];
            REG_TABLE_ENTRIES:   table_entries   = value[12:0];
            REG_CACHE_VALID:     cache_valid     = value[0];
            REG_BACKING_PRESENT: backing_present = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned results_due();
         return offsets_due.size();
      endfunction

      function void resolve_request(resolver_req_type r);
         resolver_rsp_type e;
         logic             found;
         int unsigned      n;
         int unsigned      lo;
         int unsigned      hi;
         int unsigned      mid;
         int unsigned      idx;
         logic [31:0]      base;
         logic [31:0]      offset;
         e      = '0;
         found  = 1'b0;
         idx    = 0;
         base   = 32'(HEADER_BYTES);
         offset = '0;
         if (r.func == FUNC_LOAD) begin
            cp_table[r.table_slot] = r.table_word;
            loads++;
         end else if (cache_valid && glyph_bytes != 0 &&
                      r.requested_size == 16'(glyph_bytes)) begin
            if (table_mode) begin
               n = (table_entries > TABLE_DEPTH) ? TABLE_DEPTH : table_entries;
               if (n != 0 && r.codepoint <= KEY_MAX) begin
                  lo = 0;
                  hi = n;
                  while (lo < hi && !found) begin
                     mid = lo + (hi - lo) / 2;
                     if (32'(cp_table[mid]) == r.codepoint) begin
                        found = 1'b1;
                        idx   = mid;
                     end else if (32'(cp_table[mid]) < r.codepoint) begin
                        lo = mid + 1;
                     end else begin
                        hi = mid;
                     end
                  end
                  if (found) base = 32'(HEADER_BYTES) + n * 2;
               end
            end else if (r.codepoint - RANGE_FIRST < 32'(range_entries)) begin
               found = 1'b1;
               idx   = r.codepoint - RANGE_FIRST;
            end
            if (found) begin
               hit_count++;
               offset           = base + idx * 32'(glyph_bytes);
               e.source         = SRC_HIT;
               e.byte_offset    = offset[27:0];
               e.bytes_returned = glyph_bytes;
            end else begin
               miss_count++;
               if (backing_present && r.codepoint < BACKING_GLYPHS) begin
                  offset           = r.codepoint * 32'(glyph_bytes);
                  e.source         = SRC_BACKING;
                  e.byte_offset    = offset[27:0];
                  e.bytes_returned = glyph_bytes;
                  fallbacks++;
               end
            end
         end
         e.hits_total   = hit_count;
         e.misses_total = miss_count;
         offsets_due.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(resolver_rsp_type got);
         resolver_rsp_type e;
         if (offsets_due.size() == 0) begin
            $error("response with nothing outstanding: source %0d offset 0x%0h",
                   got.source, got.byte_offset);
            errors++;
            return;
         end
         e = offsets_due.pop_front();
         checked++;
         compare_field("source", 32'(e.source), 32'(got.source));
         compare_field("byte_offset", 32'(e.byte_offset), 32'(got.byte_offset));
         compare_field("bytes_returned", 32'(e.bytes_returned), 32'(got.bytes_returned));
         compare_field("hits_total", e.hits_total, got.hits_total);
         compare_field("misses_total", e.misses_total, got.misses_total);
      endfunction
   endclass

   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic                   req_func           = FUNC_LOOKUP;
   logic [31:0]            req_codepoint      = '0;
   logic [15:0]            req_requested_size = '0;
   logic [11:0]            req_table_slot     = '0;
   logic [15:0]            req_table_word     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [1:0]             rsp_source;
   logic [27:0]            rsp_byte_offset;
   logic [12:0]            rsp_bytes_returned;
   logic [31:0]            rsp_hits_total;
   logic [31:0]            rsp_misses_total;
   logic                   csr_we             = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   resolver_scoreboard sb;
   bit                 quiet       = 1'b0;
   int unsigned        stall_left  = 0;
   int unsigned        cycles      = 0;

   glyph_address_resolver #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_codepoint      (req_codepoint),
      .req_requested_size (req_requested_size),
      .req_table_slot     (req_table_slot),
      .req_table_word     (req_table_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_source         (rsp_source),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_bytes_returned (rsp_bytes_returned),
      .rsp_hits_total     (rsp_hits_total),
      .rsp_misses_total   (rsp_misses_total),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic resolver_req_type lookup_item(logic [31:0] cp, logic [15:0] size);
      resolver_req_type r;
      r.func           = FUNC_LOOKUP;
      r.codepoint      = cp;
      r.requested_size = size;
      r.table_slot     = 12'($urandom);
      r.table_word     = 16'($urandom);
      return r;
   endfunction

   function automatic resolver_req_type load_item(logic [11:0] slot, logic [15:0] word);
      resolver_req_type r;
      r.func           = FUNC_LOAD;
      r.codepoint      = $urandom;
      r.requested_size = 16'($urandom);
      r.table_slot     = slot;
      r.table_word     = word;
      return r;
   endfunction

   // whole-table searches for these keys only probe loaded slots
   function automatic logic [31:0] wide_key(logic [31:0] cp);
      int unsigned slot;
      if (cp > KEY_MAX || cp < 32'(sb.cp_table[LOADED_SLOTS])) return cp;
      slot = LOADED_SLOTS + SPARSE_STEP *
             $urandom_range((TABLE_DEPTH - LOADED_SLOTS) / SPARSE_STEP - 1);
      return 32'(sb.cp_table[slot]);
   endfunction

   // mostly lookups aimed at the current cache contents, some near misses, noise and table loads
   function automatic resolver_req_type random_item();
      int unsigned pick;
      int unsigned n;
      logic [31:0] cp;
      logic [15:0] size;
      pick = $urandom_range(99);
      if (pick < 4)
         return load_item(12'($urandom_range(LOADED_SLOTS - 1)), 16'($urandom));
      n    = (sb.table_entries > TABLE_DEPTH) ? TABLE_DEPTH : sb.table_entries;
      pick = $urandom_range(99);
      if (sb.table_mode && n != 0 && pick < 55) begin
         cp = 32'(sb.cp_table[$urandom_range(n - 1)]);
         if (pick >= 45) cp = cp + 1;
      end else if (!sb.table_mode && pick < 55) begin
         if (pick < 45)
            cp = (sb.range_entries == 0) ? 32'd0 : $urandom_range(sb.range_entries - 1);
         else
            cp = 32'(sb.range_entries) - 32'($urandom_range(1));
      end else if (pick < 70) begin
         cp = $urandom_range(32'h0000_FFFF);
      end else if (pick < 85) begin
         cp = $urandom;
      end else begin
         case ($urandom_range(3))
            0:       cp = 32'd0;
            1:       cp = KEY_MAX;
            2:       cp = BACKING_GLYPHS;
            default: cp = 32'hFFFF_FFFF;
         endcase
      end
      if (sb.table_mode && n > LOADED_SLOTS) cp = wide_key(cp);
      pick = $urandom_range(99);
      if (pick < 88)
         size = 16'(sb.glyph_bytes);
      else if (pick < 94)
         size = 16'(sb.glyph_bytes) ^ (16'd1 << $urandom_range(15));
      else
         size = 16'($urandom);
      return lookup_item(cp, size);
   endfunction

   task automatic send_request(resolver_req_type r);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= r.func;
      req_codepoint      <= r.codepoint;
      req_requested_size <= r.requested_size;
      req_table_slot     <= r.table_slot;
      req_table_word     <= r.table_word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.resolve_request(r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.results_due() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   always @(posedge clock) begin : rsp_side
      resolver_rsp_type seen;
      int unsigned      g;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_source, rsp_byte_offset, rsp_bytes_returned,
                    rsp_hits_total, rsp_misses_total};
            sb.check_response(seen);
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
         end else begin
            g = ($urandom_range(2) == 0) ? pick_gap() : 0;
            rsp_stall  <= (g != 0);
            stall_left <= (g != 0) ? g - 1 : 0;
         end
      end
   end

   initial begin : stimulus
      int unsigned           random_items;
      int unsigned           settings;
      int unsigned           count;
      int unsigned           roll;
      logic [CSR_DATA_W-1:0] value;
      random_items = 0;
      settings     = 0;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: cache invalid, so lookups return nothing
      send_request(load_item(12'd0, 16'h0005));
      send_request(lookup_item(32'd0, 16'd0));
      settle();

      // range mode edges with one byte glyphs
      set_reg(REG_GLYPH_BYTES, 17'd1);
      set_reg(REG_CACHE_VALID, 17'd1);
      set_reg(REG_BACKING_PRESENT, 17'd1);
      send_request(lookup_item(32'd0, 16'd1));
      send_request(lookup_item(32'd2999, 16'd1));
      send_request(lookup_item(32'd3000, 16'd1));
      send_request(lookup_item(KEY_MAX, 16'd1));
      send_request(lookup_item(BACKING_GLYPHS, 16'd1));
      send_request(lookup_item(32'hFFFF_FFFF, 16'd1));
      send_request(lookup_item(32'd5, 16'hFFFF));
      send_request(lookup_item(32'd5, 16'h8001));
      settle();

      // largest in-range hit offset
      set_reg(REG_GLYPH_BYTES, 17'd4096);
      set_reg(REG_RANGE_ENTRIES, 17'd65536);
      send_request(lookup_item(KEY_MAX, 16'd4096));
      send_request(lookup_item(BACKING_GLYPHS, 16'd4096));
      settle();

      // fallback offset that wraps past 28 bits
      set_reg(REG_GLYPH_BYTES, 17'd8191);
      set_reg(REG_RANGE_ENTRIES, 17'd0);
      send_request(lookup_item(KEY_MAX, 16'd8191));
      send_request(lookup_item(32'd0, 16'd8191));
      settle();

      // zero glyph size disables lookups
      set_reg(REG_GLYPH_BYTES, 17'd0);
      send_request(lookup_item(32'd0, 16'd0));
      settle();

      // small sorted table, miss without fallback
      set_reg(REG_GLYPH_BYTES, 17'd3);
      set_reg(REG_TABLE_MODE, 17'd1);
      set_reg(REG_BACKING_PRESENT, 17'd0);
      set_reg(REG_TABLE_ENTRIES, 17'd4);
      send_request(load_item(12'd0, 16'd5));
      send_request(load_item(12'd1, 16'd10));
      send_request(load_item(12'd2, 16'd20));
      send_request(load_item(12'd3, 16'hFFFF));
      send_request(lookup_item(32'd5, 16'd3));
      send_request(lookup_item(32'd20, 16'd3));
      send_request(lookup_item(KEY_MAX, 16'd3));
      send_request(lookup_item(32'd7, 16'd3));
      send_request(lookup_item(32'h0001_0005, 16'd3));
      settle();
      set_reg(REG_TABLE_ENTRIES, 17'd0);
      send_request(lookup_item(32'd5, 16'd3));
      settle();

      // sorted words in the low slots and in every SPARSE_STEP-th slot above them
      for (int unsigned s = 0; s < TABLE_DEPTH; s++)
         if (s < LOADED_SLOTS || s % SPARSE_STEP == 0)
            send_request(load_item(12'(s), 16'(s * 16 + $urandom_range(15))));

      while (random_items < RANDOM_ITEMS) begin
         settle();
         quiet = ($urandom_range(4) == 0);
         set_reg(REG_TABLE_MODE, (settings < 2) ? 17'd1 : 17'($urandom_range(1)));
         roll = $urandom_range(99);
         if (roll < 10)      value = 17'd1;
         else if (roll < 20) value = 17'd4096;
         else if (roll < 25) value = 17'd8191;
         else if (roll < 30) value = 17'd0;
         else                value = 17'($urandom_range(4096, 1));
         set_reg(REG_GLYPH_BYTES, value);
         case ($urandom_range(11))
            0:       value = 17'd0;
            1:       value = 17'd1;
            2:       value = 17'(RANGE_RESET);
            3:       value = 17'd65535;
            4:       value = 17'd65536;
            5:       value = 17'd131071;
            default: value = 17'($urandom_range(65536));
         endcase
         set_reg(REG_RANGE_ENTRIES, value);
         roll = $urandom_range(99);
         if (settings == 0)  value = 17'd4096;
         else if (settings == 1) value = 17'd8191;
         else if (roll < 50) value = 17'($urandom_range(64, 1));
         else if (roll < 65) value = 17'($urandom_range(LOADED_SLOTS));
         else if (roll < 75) value = 17'd0;
         else if (roll < 80) value = 17'd1;
         else if (roll < 90) value = 17'd4096;
         else                value = 17'd8191;
         set_reg(REG_TABLE_ENTRIES, value);
         set_reg(REG_CACHE_VALID, ($urandom_range(9) != 0) ? 17'd1 : 17'd0);
         set_reg(REG_BACKING_PRESENT, 17'($urandom_range(1)));
         settings++;
         // small tables get fresh sorted contents
         if (sb.table_mode && sb.table_entries != 0 && sb.table_entries <= 64) begin
            for (int unsigned s = 0; s < sb.table_entries; s++)
               send_request(load_item(12'(s), 16'(s * 16 + $urandom_range(15))));
            random_items += sb.table_entries;
         end
         count = $urandom_range(70, 50);
         for (int unsigned i = 0; i < count; i++)
            send_request(random_item());
         random_items += count;
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.results_due() != 0) begin
         $error("%0d responses never arrived", sb.results_due());
         sb.errors++;
      end
      $display("tb: %0d responses checked: %0d hits, %0d backing fallbacks, %0d table loads",
               sb.checked, sb.hit_count, sb.fallbacks, sb.loads);
      $display("tb: %0d randomized register settings, %0d randomized transactions",
               settings, random_items);
      if (sb.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
